// File: sv/tpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg: shared definitions for the telemetry packet deframer
// Sizes, status codes and the CRC-32C byte update used by the deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int MAX_PACKET_BYTES = 4096;
    localparam int MIN_PACKET_BYTES = 28;
    localparam int CAPTURE_BYTES    = 24;
    localparam int TAIL_BYTES       = 4;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    typedef logic [CNT_W-1:0] t_count;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    // Reflected CRC-32C update for one byte, LSB first.
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
        end
        return crc;
    endfunction

endpackage
`default_nettype wire

// File: sv/tpd_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_in_if: packet byte channel
// Valid/ready channel carrying one packet byte and its end-of-packet flag.
// ----------------------------------------------------------------------------
interface tpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_packet;

    modport source (output valid, output data_byte, output end_of_packet, input ready);
    modport sink   (input valid, input data_byte, input end_of_packet, output ready);
endinterface
`default_nettype wire

// File: sv/tpd_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_out_if: packet status channel
// Valid/ready channel carrying the status and the decoded record of a packet.
// ----------------------------------------------------------------------------
interface tpd_out_if;
    logic              valid;
    logic              ready;
    tpd_pkg::t_status  status;
    logic [63:0]       timestamp;
    logic [31:0]       source_tag;
    logic [31:0]       dest_tag;
    logic [63:0]       latency_bits;
    logic [31:0]       received_crc;

    modport source (output valid, output status, output timestamp, output source_tag,
                    output dest_tag, output latency_bits, output received_crc,
                    input ready);
    modport sink   (input valid, input status, input timestamp, input source_tag,
                    input dest_tag, input latency_bits, input received_crc,
                    output ready);
endinterface
`default_nettype wire

// File: sv/telemetry_packet_deframer_crc32c_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// telemetry_packet_deframer_crc32c_unit: CRC-32C checked record deframer
// Channel   Dir  Payload                                       Transfers
// i_in      in   data_byte, end_of_packet                      one per byte
// o_out     out  status, timestamp, source_tag, dest_tag,      one per packet
//                latency_bits, received_crc
// The per-byte state (tail delay line, count, CRC, captures) updates on the
// input transfer, and the status of a final byte is in the output register
// in the cycle after that transfer. A byte is accepted whenever the output
// register is empty or is being taken in the same cycle. Synchronous
// active-low reset clears all packet state and the output valid.
// ----------------------------------------------------------------------------
module telemetry_packet_deframer_crc32c_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    tpd_in_if.sink       i_in,
    tpd_out_if.source    o_out
);
    import tpd_pkg::*;

    logic [31:0] r_tail,    n_tail;
    t_count      r_count,   n_count;
    logic [31:0] r_crc,     n_crc;
    logic [63:0] r_time,    n_time;
    logic [31:0] r_service, n_service;
    logic [31:0] r_target,  n_target;
    logic [63:0] r_latency, n_latency;

    logic        r_out_valid;
    t_status     r_status,  n_status;
    logic [63:0] r_o_time,  n_o_time;
    logic [31:0] r_o_serv,  n_o_serv;
    logic [31:0] r_o_targ,  n_o_targ;
    logic [63:0] r_o_lat,   n_o_lat;
    logic [31:0] r_o_crc,   n_o_crc;

    logic        in_xfer;
    logic [31:0] crc_upd;
    t_count      count_after;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_comb begin
        // The byte leaving the delay line is folded once four bytes are held.
        crc_upd = (r_count >= t_count'(TAIL_BYTES)) ? crc32c_byte(r_crc, r_tail[7:0])
                                                    : r_crc;
        count_after = (r_count == t_count'(MAX_PACKET_BYTES)) ? r_count
                                                              : r_count + t_count'(1);
        n_tail    = {i_in.data_byte, r_tail[31:8]};
        n_crc     = crc_upd;
        n_count   = count_after;
        n_time    = r_time;
        n_service = r_service;
        n_target  = r_target;
        n_latency = r_latency;
        if (r_count < t_count'(8)) begin
            n_time[{r_count[2:0], 3'b000} +: 8] = i_in.data_byte;
        end else if (r_count < t_count'(12)) begin
            n_service[{r_count[1:0], 3'b000} +: 8] = i_in.data_byte;
        end else if (r_count < t_count'(16)) begin
            n_target[{r_count[1:0], 3'b000} +: 8] = i_in.data_byte;
        end else if (r_count < t_count'(CAPTURE_BYTES)) begin
            n_latency[{r_count[2:0], 3'b000} +: 8] = i_in.data_byte;
        end

        n_status = ST_OK;
        n_o_time = 64'd0;
        n_o_serv = 32'd0;
        n_o_targ = 32'd0;
        n_o_lat  = 64'd0;
        n_o_crc  = 32'd0;
        if (count_after < t_count'(MIN_PACKET_BYTES)) begin
            n_status = ST_SHORT;
        end else if (~crc_upd != n_tail) begin
            n_status = ST_CRC_ERR;
            n_o_crc  = n_tail;
        end else begin
            n_o_time = n_time;
            n_o_serv = n_service;
            n_o_targ = n_target;
            n_o_lat  = n_latency;
            n_o_crc  = n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail      <= 32'd0;
            r_count     <= '0;
            r_crc       <= CRC_INIT;
            r_time      <= 64'd0;
            r_service   <= 32'd0;
            r_target    <= 32'd0;
            r_latency   <= 64'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                if (i_in.end_of_packet) begin
                    // Packet state returns to its reset value for the next packet.
                    r_tail    <= 32'd0;
                    r_count   <= '0;
                    r_crc     <= CRC_INIT;
                    r_time    <= 64'd0;
                    r_service <= 32'd0;
                    r_target  <= 32'd0;
                    r_latency <= 64'd0;
                end else begin
                    r_tail    <= n_tail;
                    r_count   <= n_count;
                    r_crc     <= n_crc;
                    r_time    <= n_time;
                    r_service <= n_service;
                    r_target  <= n_target;
                    r_latency <= n_latency;
                end
            end
            if (in_xfer && i_in.end_of_packet) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.end_of_packet) begin
            r_status <= n_status;
            r_o_time <= n_o_time;
            r_o_serv <= n_o_serv;
            r_o_targ <= n_o_targ;
            r_o_lat  <= n_o_lat;
            r_o_crc  <= n_o_crc;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_status;
    assign o_out.timestamp    = r_o_time;
    assign o_out.source_tag   = r_o_serv;
    assign o_out.dest_tag     = r_o_targ;
    assign o_out.latency_bits = r_o_lat;
    assign o_out.received_crc = r_o_crc;

endmodule
`default_nettype wire
